/* design/dptq_pkg.sv */
// ----------------------------------------------------------------------------
// dptq_pkg
// Shared types and codes of the dual priority packet transmit queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dptq_pkg;

  localparam int BYTE_W = 8;
  localparam int FILL_W = 4;

  // Request kinds carried on the input tuser bit 0.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Enqueue status codes reported with every result.
  localparam logic [1:0] ENQ_TICK   = 2'd0;
  localparam logic [1:0] ENQ_ACCEPT = 2'd1;
  localparam logic [1:0] ENQ_COMMIT = 2'd2;
  localparam logic [1:0] ENQ_DROP   = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } dptq_state_t;

  // Part of a result that is known when the transaction is accepted.
  typedef struct packed {
    logic       send;
    logic [1:0] status;
  } dptq_pend_t;

endpackage

`default_nettype wire

/* design/dptq_ram.sv */
// ----------------------------------------------------------------------------
// dptq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dptq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/dptq_qptr.sv */
// ----------------------------------------------------------------------------
// dptq_qptr
// Ring pointers and packet count of one packet queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dptq_qptr #(
  parameter int DEPTH = 8,
  parameter int SW    = 4
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  wire           pop,
  output logic [SW-1:0] head,
  output logic [SW-1:0] tail,
  output logic [SW-1:0] used,
  output logic          full
);

  // The ring has one slot more than the queue depth, so that the packet
  // being transmitted keeps its slot while a new packet is written.
  localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH);

  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [SW-1:0] used_r, used_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    used_nxt = used_r;
    if (push) begin
      head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
    end
    if (pop) begin
      tail_nxt = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   used_nxt = used_r + 1'b1;
      2'b01:   used_nxt = used_r - 1'b1;
      default: used_nxt = used_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      used_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      used_r <= used_nxt;
    end
  end

  assign head = head_r;
  assign tail = tail_r;
  assign used = used_r;
  assign full = (used_r >= SW'(DEPTH));

endmodule

`default_nettype wire

/* design/dual_priority_packet_tx_queue.sv */
// Result path: a transaction accepted in IDLE moves the sequencer to RESP,
// which loads its result into the output register once that register is free.
// Flow: no new transaction is taken until the result of the previous one
// has been loaded into the output register and the sequencer is back in IDLE.
// Reset: synchronous, active low; clears all pointers, counts and control flags.
// The packet store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// dual_priority_packet_tx_queue
// Transmit packet scheduler with a normal and a priority packet queue that
// share one packet store; hands out at most one byte per transmitter-ready tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_priority_packet_tx_queue #(
  parameter int NORMAL_DEPTH = 8,
  parameter int PRIO_DEPTH   = 8,
  parameter int MAX_PACKET   = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input channel.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire  [1:0]  in_tuser,   // [0] req_type, [1] high_priority
  input  wire         in_tlast,   // last_byte
  // Result channel.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [7:0] tx_byte, [9:8] enq_status, [10] busy_after,
                                  // [14:11] normal_fill, [18:15] priority_fill,
                                  // [23:19] zero
  output logic        out_tuser,  // tx_valid
  output logic        out_tlast   // tx_packet_last
);

  import dptq_pkg::*;

  // Slot numbers cover the deeper ring, including its extra slot.
  localparam int MAXD      = (NORMAL_DEPTH > PRIO_DEPTH) ? NORMAL_DEPTH : PRIO_DEPTH;
  localparam int SW        = $clog2(MAXD + 1);
  localparam int PW        = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam int LW        = $clog2(MAX_PACKET + 1);
  localparam int AW        = 1 + SW + PW;
  localparam int RAM_DEPTH = 2 ** AW;
  localparam int ENTRY_W   = BYTE_W + 1;
  localparam int PAD_W     = 24 - BYTE_W - 2 - 1 - 2 * FILL_W;

  localparam logic [LW-1:0] MAX_LEN  = LW'(MAX_PACKET);
  localparam logic [PW-1:0] LAST_POS = PW'(MAX_PACKET - 1);

  // Input fields.
  logic              req_type;
  logic              hp;
  logic              last_in;
  logic [BYTE_W-1:0] din;

  assign req_type = in_tuser[0];
  assign hp       = in_tuser[1];
  assign last_in  = in_tlast;
  assign din      = in_tdata[BYTE_W-1:0];

  // Sequencer state.
  dptq_state_t state_r, state_nxt;
  logic        in_acc;
  logic        resp_fire;

  // Packet writer state.
  logic              write_open_r, write_open_nxt;
  logic              write_drop_r, write_drop_nxt;
  logic              write_prio_r, write_prio_nxt;
  logic [LW-1:0]     write_len_r,  write_len_nxt;
  logic [BYTE_W-1:0] prev_byte_r,  prev_byte_nxt;

  // Active packet state. The active packet is read in place from its slot.
  logic          sending_r,  sending_nxt;
  logic          done_r,     done_nxt;
  logic          act_q_r,    act_q_nxt;
  logic [SW-1:0] act_slot_r, act_slot_nxt;
  logic [PW-1:0] act_pos_r,  act_pos_nxt;

  dptq_pend_t pend_r, pend_nxt;

  // Result register.
  logic              out_valid_r;
  logic              out_send_r;
  logic              out_last_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [1:0]        out_status_r;
  logic              out_busy_r;
  logic [FILL_W-1:0] out_nfill_r;
  logic [FILL_W-1:0] out_pfill_r;

  // Queue pointers.
  logic          n_push, n_pop, p_push, p_pop;
  logic [SW-1:0] n_head, n_tail, n_used;
  logic [SW-1:0] p_head, p_tail, p_used;
  logic          n_full, p_full;

  // Packet store port signals.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Decode helpers for the write path.
  logic          wq;
  logic          wdrop;
  logic [LW-1:0] wlen;
  logic [SW-1:0] whead;
  logic          commit;
  logic          load_req;
  logic          p_avail;
  logic          n_avail;

  dptq_qptr #(.DEPTH(NORMAL_DEPTH), .SW(SW)) u_nq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (n_push),
    .pop   (n_pop),
    .head  (n_head),
    .tail  (n_tail),
    .used  (n_used),
    .full  (n_full)
  );

  dptq_qptr #(.DEPTH(PRIO_DEPTH), .SW(SW)) u_pq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (p_push),
    .pop   (p_pop),
    .head  (p_head),
    .tail  (p_tail),
    .used  (p_used),
    .full  (p_full)
  );

  // Each store entry is a byte plus a flag that marks the final byte of its
  // packet, so no separate length table is needed.
  dptq_ram #(.WIDTH(ENTRY_W), .DEPTH(RAM_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: an item is taken in IDLE, and its result is formed in RESP
  // once the store read is back and the output register can take it.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RESP;
      ST_RESP: if (resp_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    resp_fire = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_RESP: resp_fire = !out_valid_r || out_tready;
      default: in_tready = 1'b0;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  // Write path field selection. The queue and the drop decision are taken from
  // the first byte of a packet and held for the rest; the length counts stored bytes from zero.
  always_comb begin
    wq    = write_open_r ? write_prio_r : hp;
    wdrop = write_open_r ? write_drop_r : (hp ? p_full : n_full);
    wlen  = write_open_r ? write_len_r : '0;
    whead = wq ? p_head : n_head;
  end

  // State update of one accepted transaction.
  always_comb begin
    write_open_nxt = write_open_r;
    write_drop_nxt = write_drop_r;
    write_prio_nxt = write_prio_r;
    write_len_nxt  = write_len_r;
    prev_byte_nxt  = prev_byte_r;
    sending_nxt    = sending_r;
    done_nxt       = done_r;
    act_q_nxt      = act_q_r;
    act_slot_nxt   = act_slot_r;
    act_pos_nxt    = act_pos_r;
    pend_nxt       = pend_r;
    ram_we         = 1'b0;
    ram_waddr      = {wq, whead, wlen[PW-1:0]};
    ram_wdata      = {last_in, din};
    ram_re         = 1'b0;
    ram_raddr      = {act_q_r, act_slot_r, act_pos_r};
    n_push         = 1'b0;
    p_push         = 1'b0;
    n_pop          = 1'b0;
    p_pop          = 1'b0;
    commit         = 1'b0;
    load_req       = 1'b0;

    if (in_acc) begin
      pend_nxt.send   = 1'b0;
      pend_nxt.status = ENQ_TICK;
      if (req_type == REQ_WRITE) begin
        pend_nxt.status = ENQ_DROP;
        write_len_nxt   = wlen;
        if (!wdrop && (wlen < MAX_LEN)) begin
          ram_we          = 1'b1;
          write_len_nxt   = wlen + 1'b1;
          prev_byte_nxt   = din;
          pend_nxt.status = ENQ_ACCEPT;
        end
        if (last_in) begin
          write_open_nxt = 1'b0;
          write_drop_nxt = 1'b0;
          write_len_nxt  = '0;
          if (!wdrop) begin
            // An overlong packet was cut off: its last stored byte is
            // rewritten with the end flag set.
            if (wlen == MAX_LEN) begin
              ram_we    = 1'b1;
              ram_waddr = {wq, whead, LAST_POS};
              ram_wdata = {1'b1, prev_byte_r};
            end
            commit          = 1'b1;
            n_push          = !wq;
            p_push          = wq;
            pend_nxt.status = ENQ_COMMIT;
            load_req        = !sending_r;
          end
        end else begin
          write_open_nxt = 1'b1;
          write_prio_nxt = wq;
          write_drop_nxt = wdrop;
        end
      end else begin
        if (sending_r && !done_r) begin
          ram_re        = 1'b1;
          act_pos_nxt   = act_pos_r + 1'b1;
          pend_nxt.send = 1'b1;
        end else begin
          // The tick after the final byte closes the packet.
          sending_nxt = 1'b0;
          load_req    = 1'b1;
        end
      end
    end

    // Load the next packet, priority queue first. A packet committed in this
    // very transaction counts as waiting.
    p_avail = (p_used != '0) || (commit && wq);
    n_avail = (n_used != '0) || (commit && !wq);
    if (load_req && (p_avail || n_avail)) begin
      act_q_nxt    = p_avail;
      act_slot_nxt = p_avail ? p_tail : n_tail;
      p_pop        = p_avail;
      n_pop        = !p_avail;
      act_pos_nxt  = '0;
      sending_nxt  = 1'b1;
      done_nxt     = 1'b0;
    end

    // The end flag of a sent byte is known once the store read returns.
    if ((state_r == ST_RESP) && pend_r.send) begin
      done_nxt = ram_rdata[BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      write_open_r <= 1'b0;
      write_drop_r <= 1'b0;
      write_prio_r <= 1'b0;
      write_len_r  <= '0;
      sending_r    <= 1'b0;
      done_r       <= 1'b0;
      act_q_r      <= 1'b0;
      act_slot_r   <= '0;
      act_pos_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_open_r <= write_open_nxt;
      write_drop_r <= write_drop_nxt;
      write_prio_r <= write_prio_nxt;
      write_len_r  <= write_len_nxt;
      sending_r    <= sending_nxt;
      done_r       <= done_nxt;
      act_q_r      <= act_q_nxt;
      act_slot_r   <= act_slot_nxt;
      act_pos_r    <= act_pos_nxt;
      if (resp_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers. Counts and the busy flag were already updated at the
  // accepting edge, so the result reads them directly in RESP.
  always_ff @(posedge clk) begin
    prev_byte_r <= prev_byte_nxt;
    pend_r      <= pend_nxt;
    if (resp_fire) begin
      out_send_r   <= pend_r.send;
      out_byte_r   <= pend_r.send ? ram_rdata[BYTE_W-1:0] : '0;
      out_last_r   <= pend_r.send && ram_rdata[BYTE_W];
      out_status_r <= pend_r.status;
      out_busy_r   <= sending_r;
      out_nfill_r  <= FILL_W'(n_used);
      out_pfill_r  <= FILL_W'(p_used);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_send_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_pfill_r, out_nfill_r, out_busy_r,
                       out_status_r, out_byte_r};

endmodule

`default_nettype wire

/* design/dptq_chk.sv */
// ----------------------------------------------------------------------------
// dptq_chk
// Port-level checks of the dual priority packet transmit queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dptq_chk #(
  parameter int NORMAL_DEPTH = 8,
  parameter int PRIO_DEPTH   = 8
) (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire        out_tuser,
  input wire        out_tlast
);

  import dptq_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A sent byte only comes from a tick and leaves a packet active.
  a_send_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[9:8] == ENQ_TICK) && out_tdata[10])
    else $error("sent byte without tick or active packet");

  // Without a sent byte, byte and end marker are zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[7:0] == 8'd0) && !out_tlast)
    else $error("byte or end marker set without a sent byte");

  // Fill counts never pass their queue depth.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((NORMAL_DEPTH > 15) || (out_tdata[14:11] <= NORMAL_DEPTH)) &&
                   ((PRIO_DEPTH > 15) || (out_tdata[18:15] <= PRIO_DEPTH)))
    else $error("fill count above queue depth");

  // One item at a time: no item is taken in the cycle after one was taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

endmodule

bind dual_priority_packet_tx_queue dptq_chk #(
  .NORMAL_DEPTH (NORMAL_DEPTH),
  .PRIO_DEPTH   (PRIO_DEPTH)
) u_dptq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual priority packet transmit queue. A list of
// requests (packet byte writes and transmitter ticks) is built up front: a
// short directed opening, then random packets and tick bursts. A clocked
// driver sends them with random gaps. Each accepted request runs through a
// behavioral scheduler that predicts the result transaction. A clocked monitor
// applies random backpressure and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dptq_pkg::*;

  localparam int Q_DEPTH     = 8;
  localparam int PKT_MAX     = 64;
  localparam int NORM_LANE   = 0;
  localparam int PRIO_LANE   = 1;
  localparam int ITEM_TARGET = 1400;
  localparam int CYCLE_LIMIT = 600000;

  // One request as the testbench sees it.
  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       hp;
    logic       eop;
  } tx_req_t;

  // One result transaction, split into its fields.
  typedef struct packed {
    logic       sent;
    logic [7:0] data;
    logic       pkt_end;
    logic [1:0] status;
    logic       busy;
    logic [3:0] nfill;
    logic [3:0] pfill;
  } tx_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  dual_priority_packet_tx_queue #(
    .NORMAL_DEPTH (Q_DEPTH),
    .PRIO_DEPTH   (Q_DEPTH),
    .MAX_PACKET   (PKT_MAX)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tx_req_t    req_queue[$];
  tx_result_t pending_results[$];
  int         errors = 0;
  int         cycles = 0;

  // Scheduler state: lane 0 is the normal queue, lane 1 the priority queue.
  logic [7:0] pkt_mem [2][Q_DEPTH][PKT_MAX];
  int         pkt_len [2][Q_DEPTH];
  int         wr_slot [2];
  int         rd_slot [2];
  int         pkt_cnt [2];
  logic [7:0] act_buf [PKT_MAX];
  int         act_len;
  int         act_pos;
  bit         sending;
  bit         wr_open;
  bit         wr_drop;
  bit         wr_prio;
  int         wr_len;

  // Moves the oldest waiting packet into the active buffer, priority first.
  task automatic load_active();
    int lane;
    if (sending) return;
    if (pkt_cnt[PRIO_LANE] > 0) lane = PRIO_LANE;
    else if (pkt_cnt[NORM_LANE] > 0) lane = NORM_LANE;
    else return;
    act_len = pkt_len[lane][rd_slot[lane]];
    for (int i = 0; i < act_len; i++) act_buf[i] = pkt_mem[lane][rd_slot[lane]][i];
    rd_slot[lane] = (rd_slot[lane] + 1) % Q_DEPTH;
    pkt_cnt[lane]--;
    act_pos = 0;
    sending = 1'b1;
  endtask

  // Works out the result of one accepted request and queues it.
  task automatic predict_tx_step(input tx_req_t it);
    tx_result_t r;
    int         lane;
    r = '0;
    r.status = ENQ_TICK;
    if (it.req == REQ_WRITE) begin
      if (!wr_open) begin
        wr_open = 1'b1;
        wr_prio = it.hp;
        wr_len  = 0;
        lane    = wr_prio ? PRIO_LANE : NORM_LANE;
        wr_drop = pkt_cnt[lane] >= Q_DEPTH;
      end
      lane = wr_prio ? PRIO_LANE : NORM_LANE;
      if (wr_drop) begin
        r.status = ENQ_DROP;
      end else if (wr_len < PKT_MAX) begin
        pkt_mem[lane][wr_slot[lane]][wr_len] = it.data;
        wr_len++;
        r.status = ENQ_ACCEPT;
      end else begin
        r.status = ENQ_DROP;
      end
      if (it.eop) begin
        wr_open = 1'b0;
        if (!wr_drop) begin
          pkt_len[lane][wr_slot[lane]] = wr_len;
          wr_slot[lane] = (wr_slot[lane] + 1) % Q_DEPTH;
          pkt_cnt[lane]++;
          r.status = ENQ_COMMIT;
          load_active();
        end
        wr_drop = 1'b0;
        wr_len  = 0;
      end
    end else begin
      if (sending && act_pos < act_len) begin
        r.sent    = 1'b1;
        r.data    = act_buf[act_pos];
        act_pos++;
        r.pkt_end = act_pos == act_len;
      end else begin
        // The tick after the final byte closes the packet and sends nothing.
        sending = 1'b0;
        act_len = 0;
        act_pos = 0;
        load_active();
      end
    end
    r.busy  = sending;
    r.nfill = pkt_cnt[NORM_LANE][3:0];
    r.pfill = pkt_cnt[PRIO_LANE][3:0];
    pending_results.push_back(r);
  endtask

  task automatic push_req(input logic req, input logic [7:0] data, input logic hp,
                          input logic eop);
    tx_req_t it;
    it.req  = req;
    it.data = data;
    it.hp   = hp;
    it.eop  = eop;
    req_queue.push_back(it);
  endtask

  // Packet with random bytes; the priority bit after the first byte is noise.
  task automatic push_packet(input int len, input logic hp);
    for (int i = 0; i < len; i++)
      push_req(REQ_WRITE, 8'($urandom), (i == 0) ? hp : 1'($urandom), i == len - 1);
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++)
      push_req(REQ_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Mostly short gaps, now and then a long one; none at all in calm phases.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Driver. The request held on the bus is predicted at the edge where it is
  // taken, and the next one is put up at that same edge.
  tx_req_t cur_req;
  int      tx_gap  = 0;
  bit      tx_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_tx_step(cur_req);
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          in_tdata  <= cur_req.data;
          in_tuser  <= {cur_req.hp, cur_req.req};
          in_tlast  <= cur_req.eop;
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
          tx_gap = pick_gap(tx_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor with random backpressure.
  int stall_left = 0;
  bit rx_calm    = 1'b0;

  always @(posedge clk) begin
    tx_result_t want;
    tx_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.sent    = out_tuser;
        got.data    = out_tdata[7:0];
        got.pkt_end = out_tlast;
        got.status  = out_tdata[9:8];
        got.busy    = out_tdata[10];
        got.nfill   = out_tdata[14:11];
        got.pfill   = out_tdata[18:15];
        if (pending_results.size() == 0) begin
          $error("result transaction with no request waiting for it");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.sent !== want.sent) begin
            $error("tx_valid: expected %0d, got %0d", want.sent, got.sent);
            errors++;
          end
          if (got.data !== want.data) begin
            $error("tx_byte: expected %0h, got %0h", want.data, got.data);
            errors++;
          end
          if (got.pkt_end !== want.pkt_end) begin
            $error("tx_packet_last: expected %0d, got %0d", want.pkt_end, got.pkt_end);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("enq_status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.busy !== want.busy) begin
            $error("busy_after: expected %0d, got %0d", want.busy, got.busy);
            errors++;
          end
          if (got.nfill !== want.nfill) begin
            $error("normal_fill: expected %0d, got %0d", want.nfill, got.nfill);
            errors++;
          end
          if (got.pfill !== want.pfill) begin
            $error("priority_fill: expected %0d, got %0d", want.pfill, got.pfill);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    bit flood;
    int r;
    flood   = 1'b0;
    sending = 1'b0;
    wr_open = 1'b0;
    wr_drop = 1'b0;
    wr_prio = 1'b0;
    wr_len  = 0;
    act_len = 0;
    act_pos = 0;
    for (int l = 0; l < 2; l++) begin
      wr_slot[l] = 0;
      rd_slot[l] = 0;
      pkt_cnt[l] = 0;
    end

    // Tick while idle, with the ignored fields all high.
    push_req(REQ_TICK, 8'hFF, 1'b1, 1'b1);
    // Single byte packet written while idle goes straight to the active buffer.
    push_req(REQ_WRITE, 8'h00, 1'b0, 1'b1);
    // Priority packet whose priority bit drops on its second byte.
    push_req(REQ_WRITE, 8'hFF, 1'b1, 1'b0);
    push_req(REQ_WRITE, 8'h5A, 1'b0, 1'b1);
    // Fill the normal queue, then a packet that finds it full is dropped.
    for (int i = 1; i <= Q_DEPTH; i++) push_req(REQ_WRITE, 8'(i), 1'b0, 1'b1);
    push_req(REQ_WRITE, 8'hC3, 1'b0, 1'b0);
    push_req(REQ_WRITE, 8'h3C, 1'b1, 1'b1);
    // Drain the active packet; the priority packet must come out first.
    push_ticks(5);

    while (req_queue.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 11) == 0) flood = !flood;
      r = $urandom_range(0, 19);
      if (r < (flood ? 14 : 7)) begin
        case ($urandom_range(0, 19))
          0:       push_packet($urandom_range(60, 70), 1'($urandom));
          1:       push_packet(PKT_MAX + $urandom_range(0, 1), 1'($urandom));
          default: push_packet($urandom_range(1, 8), 1'($urandom));
        endcase
      end else if (r < 18) begin
        push_ticks(($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12));
      end else if (r == 18) begin
        // Start of a packet that continues after whatever comes next.
        for (int i = $urandom_range(1, 4); i > 0; i--)
          push_req(REQ_WRITE, 8'($urandom), 1'($urandom), 1'b0);
      end else begin
        push_req(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Checked between edges, once the clocked blocks have settled.
    while (req_queue.size() != 0 || in_tvalid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
